// File: rtl/grhc_pkg.sv
package grhc_pkg;

  // Fixed field widths.
  localparam int unsigned HUE_BITS       = 16;
  localparam int unsigned LEVEL_BITS     = 16;
  localparam int unsigned CHANNEL_BITS   = 8;
  localparam int unsigned SECTOR_BITS    = 3;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [LEVEL_BITS:0] LEVEL_ONE = (LEVEL_BITS + 1)'(1) << LEVEL_BITS;
  localparam logic [HUE_BITS:0]   HUE_ONE   = (HUE_BITS + 1)'(1) << HUE_BITS;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HUE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SATURATION = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BRIGHTNESS = 2'd2;

  // Register reset values.
  localparam logic [HUE_BITS-1:0]   HUE_STEP_RST   = 16'd40503;
  localparam logic [LEVEL_BITS-1:0] SATURATION_RST = 16'd58982;
  localparam logic [LEVEL_BITS-1:0] BRIGHTNESS_RST = 16'd62259;

  // Hue sectors of the six-sector HSV formula.
  localparam logic [SECTOR_BITS-1:0] SEC_RED_YELLOW     = 3'd0;
  localparam logic [SECTOR_BITS-1:0] SEC_YELLOW_GREEN   = 3'd1;
  localparam logic [SECTOR_BITS-1:0] SEC_GREEN_CYAN     = 3'd2;
  localparam logic [SECTOR_BITS-1:0] SEC_CYAN_BLUE      = 3'd3;
  localparam logic [SECTOR_BITS-1:0] SEC_BLUE_MAGENTA   = 3'd4;

  typedef struct packed {
    logic [HUE_BITS-1:0]    hue;
    logic [SECTOR_BITS-1:0] sector;
    logic [HUE_BITS-1:0]    frac;
  } hue_entry_t;

  // Packed so that red lands in the lowest bits of tdata.
  typedef struct packed {
    logic [HUE_BITS-1:0]     hue_used;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;
  } color_t;

endpackage

// File: rtl/grhc_front.sv
module grhc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic                              load_start_i,
  input  logic [grhc_pkg::HUE_BITS-1:0]     start_hue_i,
  input  logic [grhc_pkg::HUE_BITS-1:0]     hue_step_i,
  input  logic                              full_i,
  output logic                              push_o,
  output grhc_pkg::hue_entry_t              entry_o
);

  logic [grhc_pkg::HUE_BITS-1:0] phase_q, phase_d;
  logic [grhc_pkg::HUE_BITS-1:0] base;
  logic [grhc_pkg::HUE_BITS+2:0] hue_x6;

  assign ready_o = !full_i;
  assign push_o  = valid_i && ready_o;

  assign base    = load_start_i ? start_hue_i : phase_q;
  assign phase_d = base + hue_step_i;

  // hue * 6 as a sum of two shifts; the integer part is the sector.
  assign hue_x6 = {1'b0, phase_d, 2'b00} + {2'b00, phase_d, 1'b0};

  assign entry_o.hue    = phase_d;
  assign entry_o.sector = hue_x6[grhc_pkg::HUE_BITS +: grhc_pkg::SECTOR_BITS];
  assign entry_o.frac   = hue_x6[grhc_pkg::HUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

// File: rtl/grhc_queue.sv
module grhc_queue #(
  parameter int unsigned DEPTH = grhc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  grhc_pkg::hue_entry_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output grhc_pkg::hue_entry_t pop_data_o,
  output logic                 empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  grhc_pkg::hue_entry_t slots_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o     = (count_q == FULL_CNT);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/grhc_back.sv
module grhc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  grhc_pkg::hue_entry_t            entry_i,
  output logic                            pop_o,
  input  logic [grhc_pkg::LEVEL_BITS-1:0] saturation_i,
  input  logic [grhc_pkg::LEVEL_BITS-1:0] brightness_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output grhc_pkg::color_t                color_o
);

  localparam int unsigned LB = grhc_pkg::LEVEL_BITS;
  localparam int unsigned HB = grhc_pkg::HUE_BITS;
  localparam int unsigned CB = grhc_pkg::CHANNEL_BITS;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FRAC  = 3'b010,
    B_LEVEL = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  grhc_pkg::hue_entry_t work_q;
  logic [LB-1:0] fs_q, gs_q;
  logic          out_valid_q;
  grhc_pkg::color_t out_q;

  logic [HB:0]      one_minus_f;
  logic [HB+LB:0]   fs_prod, gs_prod;
  logic [2*LB:0]    p_prod, q_prod, t_prod;
  logic [LB-1:0]    p_lvl, q_lvl, t_lvl, v_lvl;
  logic [LB-1:0]    r_lvl, g_lvl, b_lvl;
  logic             out_free;
  logic             load_out;

  assign out_free = !out_valid_q || ready_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign load_out = (state_q == B_LEVEL) && out_free;

  // First step: f*S and (1-f)*S, floored to the level format.
  assign one_minus_f = grhc_pkg::HUE_ONE - {1'b0, work_q.frac};
  assign fs_prod = (HB + LB + 1)'({1'b0, work_q.frac} * saturation_i);
  assign gs_prod = (HB + LB + 1)'(one_minus_f * saturation_i);

  // Second step: the three scaled levels.
  assign v_lvl  = brightness_i;
  assign p_prod = (2 * LB + 1)'(v_lvl * (grhc_pkg::LEVEL_ONE - {1'b0, saturation_i}));
  assign q_prod = (2 * LB + 1)'(v_lvl * (grhc_pkg::LEVEL_ONE - {1'b0, fs_q}));
  assign t_prod = (2 * LB + 1)'(v_lvl * (grhc_pkg::LEVEL_ONE - {1'b0, gs_q}));
  assign p_lvl  = p_prod[LB +: LB];
  assign q_lvl  = q_prod[LB +: LB];
  assign t_lvl  = t_prod[LB +: LB];

  always_comb begin
    case (work_q.sector)
      grhc_pkg::SEC_RED_YELLOW: begin
        r_lvl = v_lvl; g_lvl = t_lvl; b_lvl = p_lvl;
      end
      grhc_pkg::SEC_YELLOW_GREEN: begin
        r_lvl = q_lvl; g_lvl = v_lvl; b_lvl = p_lvl;
      end
      grhc_pkg::SEC_GREEN_CYAN: begin
        r_lvl = p_lvl; g_lvl = v_lvl; b_lvl = t_lvl;
      end
      grhc_pkg::SEC_CYAN_BLUE: begin
        r_lvl = p_lvl; g_lvl = q_lvl; b_lvl = v_lvl;
      end
      grhc_pkg::SEC_BLUE_MAGENTA: begin
        r_lvl = t_lvl; g_lvl = p_lvl; b_lvl = v_lvl;
      end
      default: begin
        r_lvl = v_lvl; g_lvl = p_lvl; b_lvl = q_lvl;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) state_d = B_FRAC;
      end
      B_FRAC: begin
        state_d = B_LEVEL;
      end
      B_LEVEL: begin
        if (out_free) state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= entry_i;
    end
    if (state_q == B_FRAC) begin
      fs_q <= fs_prod[HB +: LB];
      gs_q <= gs_prod[HB +: LB];
    end
    if (load_out) begin
      out_q.red      <= r_lvl[LB-1 -: CB];
      out_q.green    <= g_lvl[LB-1 -: CB];
      out_q.blue     <= b_lvl[LB-1 -: CB];
      out_q.hue_used <= work_q.hue;
    end
  end

  assign valid_o = out_valid_q;
  assign color_o = out_q;

endmodule

// File: rtl/golden_ratio_hue_color_generator.sv
// An input is queued, popped into the work register, then its fractional products and
// color are registered. The three-step back-end sequencer (fetch from queue, fractional
// products, level products) pops nothing until the output register takes the color; the
// front end takes an item every cycle until the 2-entry queue fills. The output register
// holds a finished color while the next is computed. Reset clears the hue phase to zero,
// loads the default step, saturation and brightness, and empties the queue.
module golden_ratio_hue_color_generator #(
  parameter int unsigned QUEUE_DEPTH = grhc_pkg::QUEUE_DEPTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [15:0]                             s_axis_tdata,  // [15:0] start_hue
  input  logic [0:0]                              s_axis_tuser,  // [0] load_start
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [39:24] hue_used
  output logic [39:0]                             m_axis_tdata,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [grhc_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [15:0]                             cfg_data_i
);

  logic [grhc_pkg::HUE_BITS-1:0]   hue_step_q;
  logic [grhc_pkg::LEVEL_BITS-1:0] saturation_q, brightness_q;
  logic                            cfg_write;

  logic                 push, pop, full, empty;
  grhc_pkg::hue_entry_t push_entry, pop_entry;
  grhc_pkg::color_t     color;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_step_q   <= grhc_pkg::HUE_STEP_RST;
      saturation_q <= grhc_pkg::SATURATION_RST;
      brightness_q <= grhc_pkg::BRIGHTNESS_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        grhc_pkg::CFG_HUE_STEP:   hue_step_q   <= cfg_data_i;
        grhc_pkg::CFG_SATURATION: saturation_q <= cfg_data_i;
        grhc_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  grhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .load_start_i (s_axis_tuser[0]),
    .start_hue_i  (s_axis_tdata),
    .hue_step_i   (hue_step_q),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  grhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (empty)
  );

  grhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .saturation_i (saturation_q),
    .brightness_i (brightness_q),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .color_o      (color)
  );

  assign m_axis_tdata = color;

endmodule
